[rtl/pcli_pkg.sv]
package pcli_pkg;

  localparam int POS_W   = 32;
  localparam int INV_W   = 32;
  localparam int FRAC_W  = 48;
  localparam int CNT_W   = 6;
  localparam int COORD_W = 5;
  localparam int IDX_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    CMD_BIN   = 1'b0,
    CMD_NEIGH = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_X   = 3'd0,
    REG_INV_Y   = 3'd1,
    REG_INV_Z   = 3'd2,
    REG_CELLS_X = 3'd3,
    REG_CELLS_Y = 3'd4,
    REG_CELLS_Z = 3'd5
  } reg_idx_t;

  // Offset of one neighbour coordinate from its home cell.
  typedef enum logic [1:0] {
    VAR_HOME = 2'd0,
    VAR_NEXT = 2'd1,
    VAR_PREV = 2'd2
  } var_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic s1_bin;
  } pipe_ctl_t;

  function automatic var_t next_var(input var_t v);
    case (v)
      VAR_HOME: next_var = VAR_NEXT;
      VAR_NEXT: next_var = VAR_PREV;
      default:  next_var = VAR_HOME;
    endcase
  endfunction

  // Periodic neighbour of coordinate n on an axis of cnt cells.
  function automatic logic [CNT_W-1:0] variant(input logic [CNT_W-1:0] n,
                                               input logic [CNT_W-1:0] cnt,
                                               input var_t sel);
    logic [CNT_W-1:0] up;
    up = n + CNT_W'(1);
    case (sel)
      VAR_NEXT: variant = (up < cnt) ? up : '0;
      VAR_PREV: variant = (n != '0) ? n - CNT_W'(1) : cnt - CNT_W'(1);
      default:  variant = n;
    endcase
  endfunction

  // Saturate a home coordinate to the last cell of its axis.
  function automatic logic [CNT_W-1:0] clamp_home(input logic [COORD_W-1:0] h,
                                                  input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] v;
    v = CNT_W'(h);
    clamp_home = (v >= cnt) ? cnt - CNT_W'(1) : v;
  endfunction

endpackage

[rtl/periodic_cell_list_indexer_top.sv]
// Channel  | handshake               | payload
// ---------+-------------------------+------------------------------------------
// request  | in_valid / in_stall     | command, pos_x/y/z, home_x/y/z
// result   | out_valid / out_stall   | cell_index, cell_x/y/z, last
// config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A bin request gives one result; a request enters every cycle when the
// result side does not stall. A neighbour request gives 27 results, one a
// cycle while the result side does not stall. It occupies the request
// register and holds in_stall high until its last result issues; the next
// request enters on the edge that issues the last. A result passes the request
// register, multiply stage, scale stage and index/output stage in order.
// Synchronous reset clears every valid bit and sets the configuration registers to 1.
// out_stall freezes only the stages that hold a waiting item; bubbles close up.
module periodic_cell_list_indexer_top #(
  parameter int MAX_CELLS_PER_AXIS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // request channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    command,
  input  logic signed [pcli_pkg::POS_W-1:0]       pos_x,
  input  logic signed [pcli_pkg::POS_W-1:0]       pos_y,
  input  logic signed [pcli_pkg::POS_W-1:0]       pos_z,
  input  logic        [pcli_pkg::COORD_W-1:0]     home_x,
  input  logic        [pcli_pkg::COORD_W-1:0]     home_y,
  input  logic        [pcli_pkg::COORD_W-1:0]     home_z,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic        [pcli_pkg::IDX_W-1:0]       cell_index,
  output logic        [pcli_pkg::COORD_W-1:0]     cell_x,
  output logic        [pcli_pkg::COORD_W-1:0]     cell_y,
  output logic        [pcli_pkg::COORD_W-1:0]     cell_z,
  output logic                                    last,
  // configuration channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [pcli_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [pcli_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W    = pcli_pkg::CNT_W;
  localparam int CNT_TOP  = (1 << CNT_W) - 1;
  // Largest count the 6-bit registers can reach after saturation.
  localparam int SAT_INT  = (MAX_CELLS_PER_AXIS > CNT_TOP) ? CNT_TOP : MAX_CELLS_PER_AXIS;
  localparam logic [CNT_W-1:0] SAT = CNT_W'(SAT_INT);
  localparam int AREA_W   = 2 * CNT_W;
  localparam int ZTERM_W  = 3 * CNT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [pcli_pkg::INV_W-1:0] inv_len_x, inv_len_y, inv_len_z;
  logic [CNT_W-1:0]           cells_x, cells_y, cells_z;
  logic [CNT_W-1:0]           cx, cy, cz;
  logic [AREA_W-1:0]          cxy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_len_x <= pcli_pkg::INV_W'(1);
      inv_len_y <= pcli_pkg::INV_W'(1);
      inv_len_z <= pcli_pkg::INV_W'(1);
      cells_x   <= CNT_W'(1);
      cells_y   <= CNT_W'(1);
      cells_z   <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcli_pkg::REG_INV_X:   inv_len_x <= cfg_data;
        pcli_pkg::REG_INV_Y:   inv_len_y <= cfg_data;
        pcli_pkg::REG_INV_Z:   inv_len_z <= cfg_data;
        pcli_pkg::REG_CELLS_X: cells_x   <= cfg_data[CNT_W-1:0];
        pcli_pkg::REG_CELLS_Y: cells_y   <= cfg_data[CNT_W-1:0];
        pcli_pkg::REG_CELLS_Z: cells_z   <= cfg_data[CNT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Effective counts: zero reads as one, large counts saturate.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    if (c == '0) begin
      eff_count = CNT_W'(1);
    end else if (c > SAT) begin
      eff_count = SAT;
    end else begin
      eff_count = c;
    end
  endfunction

  assign cx = eff_count(cells_x);
  assign cy = eff_count(cells_y);
  assign cz = eff_count(cells_z);

  // Area of one z slab, registered so the index stage has one multiply per term.
  // The user changes configuration only while the pipeline is empty, unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      cxy <= AREA_W'(1);
    end else begin
      cxy <= AREA_W'(cx) * AREA_W'(cy);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enables: a stage advances when empty or when the next one moves
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid;
  logic en1, en2, en3;

  assign en3 = !s3_valid || !out_stall;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;

  // ---------------------------------------------------------------------------
  // Stage 0: request register and neighbour sequencer
  // ---------------------------------------------------------------------------
  logic                            rq_valid;
  pcli_pkg::cmd_t                  rq_cmd;
  logic signed [pcli_pkg::POS_W-1:0]   rq_pos_x, rq_pos_y, rq_pos_z;
  logic        [pcli_pkg::COORD_W-1:0] rq_home_x, rq_home_y, rq_home_z;
  pcli_pkg::var_t                  sel_a, sel_b, sel_c;
  pcli_pkg::var_t                  sel_a_next, sel_b_next, sel_c_next;
  logic                            rq_last;
  logic                            issue;
  logic                            accept;
  logic [CNT_W-1:0]                nb_x, nb_y, nb_z;

  // The last neighbour is (prev, prev, prev); a bin request is always last.
  assign rq_last = (rq_cmd == pcli_pkg::CMD_BIN) ||
                   (sel_a == pcli_pkg::VAR_PREV && sel_b == pcli_pkg::VAR_PREV &&
                    sel_c == pcli_pkg::VAR_PREV);
  assign issue    = rq_valid && en1;
  assign in_stall = rq_valid && !(en1 && rq_last);
  assign accept   = in_valid && !in_stall;

  // Step z innermost, then y, then x.
  always_comb begin
    sel_a_next = sel_a;
    sel_b_next = sel_b;
    sel_c_next = sel_c;
    if (accept) begin
      sel_a_next = pcli_pkg::VAR_HOME;
      sel_b_next = pcli_pkg::VAR_HOME;
      sel_c_next = pcli_pkg::VAR_HOME;
    end else if (issue && !rq_last) begin
      sel_c_next = pcli_pkg::next_var(sel_c);
      if (sel_c == pcli_pkg::VAR_PREV) begin
        sel_b_next = pcli_pkg::next_var(sel_b);
        if (sel_b == pcli_pkg::VAR_PREV) begin
          sel_a_next = pcli_pkg::next_var(sel_a);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_valid <= 1'b0;
      rq_cmd   <= pcli_pkg::CMD_BIN;
      sel_a    <= pcli_pkg::VAR_HOME;
      sel_b    <= pcli_pkg::VAR_HOME;
      sel_c    <= pcli_pkg::VAR_HOME;
    end else begin
      sel_a <= sel_a_next;
      sel_b <= sel_b_next;
      sel_c <= sel_c_next;
      if (accept) begin
        rq_valid <= 1'b1;
        rq_cmd   <= pcli_pkg::cmd_t'(command);
      end else if (issue && rq_last) begin
        rq_valid <= 1'b0;
      end
    end
  end

  // Hold the payload of the request in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      rq_pos_x  <= pos_x;
      rq_pos_y  <= pos_y;
      rq_pos_z  <= pos_z;
      rq_home_x <= home_x;
      rq_home_y <= home_y;
      rq_home_z <= home_z;
    end
  end

  assign nb_x = pcli_pkg::variant(pcli_pkg::clamp_home(rq_home_x, cx), cx, sel_a);
  assign nb_y = pcli_pkg::variant(pcli_pkg::clamp_home(rq_home_y, cy), cy, sel_b);
  assign nb_z = pcli_pkg::variant(pcli_pkg::clamp_home(rq_home_z, cz), cz, sel_c);

  // ---------------------------------------------------------------------------
  // Stages 1 and 2: per-axis multiply and scale
  // ---------------------------------------------------------------------------
  pcli_pkg::cmd_t      s1_cmd;
  logic                s1_last, s2_last;
  pcli_pkg::pipe_ctl_t ctl;
  logic [CNT_W-1:0]    x2, y2, z2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= rq_valid;
      if (en2) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd  <= rq_cmd;
      s1_last <= rq_last;
    end
    if (en2) begin
      s2_last <= s1_last;
    end
  end

  // Fields in declaration order: en1, en2, s1_bin.
  assign ctl = {en1, en2, (s1_cmd == pcli_pkg::CMD_BIN)};

  pcli_axis u_axis_x (
    .clk      (clk),
    .ctl      (ctl),
    .pos      (rq_pos_x),
    .inv      (inv_len_x),
    .cnt      (cx),
    .nb_coord (nb_x),
    .coord    (x2)
  );

  pcli_axis u_axis_y (
    .clk      (clk),
    .ctl      (ctl),
    .pos      (rq_pos_y),
    .inv      (inv_len_y),
    .cnt      (cy),
    .nb_coord (nb_y),
    .coord    (y2)
  );

  pcli_axis u_axis_z (
    .clk      (clk),
    .ctl      (ctl),
    .pos      (rq_pos_z),
    .inv      (inv_len_z),
    .cnt      (cz),
    .nb_coord (nb_z),
    .coord    (z2)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: linear index and output register
  // ---------------------------------------------------------------------------
  logic [AREA_W-1:0]          y_term;
  logic [ZTERM_W-1:0]         z_term;
  logic [pcli_pkg::IDX_W-1:0] idx;
  logic [CNT_W-1:0]           x3, y3, z3;
  logic                       s3_last;

  assign y_term = AREA_W'(y2) * AREA_W'(cx);
  assign z_term = ZTERM_W'(z2) * ZTERM_W'(cxy);
  // Index wraps modulo the 15-bit field.
  assign idx    = pcli_pkg::IDX_W'(x2) + pcli_pkg::IDX_W'(y_term)
                + z_term[pcli_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cell_index <= idx;
      x3         <= x2;
      y3         <= y2;
      z3         <= z2;
      s3_last    <= s2_last;
    end
  end

  assign out_valid = s3_valid;
  assign cell_x    = x3[pcli_pkg::COORD_W-1:0];
  assign cell_y    = y3[pcli_pkg::COORD_W-1:0];
  assign cell_z    = z3[pcli_pkg::COORD_W-1:0];
  assign last      = s3_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An empty request register never holds off the request side.
  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    !rq_valid |-> !in_stall)
    else $error("request stalled with empty request register");

  // A bin request never moves the neighbour sequencer off the home cell.
  a_bin_home: assert property (@(posedge clk) disable iff (rst)
    (rq_valid && rq_cmd == pcli_pkg::CMD_BIN) |->
      (sel_a == pcli_pkg::VAR_HOME && sel_b == pcli_pkg::VAR_HOME &&
       sel_c == pcli_pkg::VAR_HOME))
    else $error("sequencer moved during a bin request");

  // An unfinished neighbour request blocks the next request.
  a_neigh_hold: assert property (@(posedge clk) disable iff (rst)
    (rq_valid && !rq_last) |-> in_stall)
    else $error("new request taken before the neighbour list ended");

  // A blocked stage-1 item stays in place.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !en2) |=> s1_valid)
    else $error("stage-1 item lost while blocked");

endmodule

[rtl/pcli_axis.sv]
module pcli_axis (
  input  logic                                clk,
  input  pcli_pkg::pipe_ctl_t                 ctl,
  input  logic signed [pcli_pkg::POS_W-1:0]   pos,
  input  logic        [pcli_pkg::INV_W-1:0]   inv,
  input  logic        [pcli_pkg::CNT_W-1:0]   cnt,
  input  logic        [pcli_pkg::CNT_W-1:0]   nb_coord,
  output logic        [pcli_pkg::CNT_W-1:0]   coord
);

  localparam int PROD_W  = pcli_pkg::POS_W + pcli_pkg::INV_W + 1;
  localparam int SCALE_W = pcli_pkg::FRAC_W + pcli_pkg::CNT_W;

  logic signed [PROD_W-1:0]             prod;
  logic        [pcli_pkg::FRAC_W-1:0]   frac;
  logic        [pcli_pkg::CNT_W-1:0]    nb;
  logic        [SCALE_W-1:0]            scaled;

  // Low bits of position times inverse length: fraction of the box.
  assign prod   = pos * $signed({1'b0, inv});
  // Scale the fraction by the cell count and floor.
  assign scaled = SCALE_W'(frac) * SCALE_W'(cnt);

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      frac <= prod[pcli_pkg::FRAC_W-1:0];
      nb   <= nb_coord;
    end
    if (ctl.en2) begin
      coord <= ctl.s1_bin ? scaled[SCALE_W-1:pcli_pkg::FRAC_W] : nb;
    end
  end

endmodule

[tb/tb_periodic_cell_list_indexer_top.sv]
module tb_periodic_cell_list_indexer_top;

  localparam int MAX_CELLS        = 32;
  localparam int SEGMENTS         = 12;
  localparam int SEG_ITEMS        = 35;
  localparam int SHOWN_MISMATCHES = 10;

  // Indexes past the last register; writes to them must leave every register alone.
  localparam logic [pcli_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [pcli_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [pcli_pkg::IDX_W-1:0]   index;
    logic [pcli_pkg::COORD_W-1:0] x;
    logic [pcli_pkg::COORD_W-1:0] y;
    logic [pcli_pkg::COORD_W-1:0] z;
    logic                         last;
  } cell_res_t;

  // Holds a private copy of the registers, works out the cells that each
  // accepted request must produce and checks them in order.
  class cell_scoreboard;
    logic [pcli_pkg::INV_W-1:0] inv_len [3];
    logic [pcli_pkg::CNT_W-1:0] cells [3];
    pcli_pkg::var_t             walk [3];
    cell_res_t                  pending_cells [$];
    int unsigned                mismatches;
    int unsigned                checked;

    function new();
      foreach (inv_len[i]) begin
        inv_len[i] = pcli_pkg::INV_W'(1);
        cells[i]   = pcli_pkg::CNT_W'(1);
      end
      walk       = '{pcli_pkg::VAR_HOME, pcli_pkg::VAR_NEXT, pcli_pkg::VAR_PREV};
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [pcli_pkg::CFG_IDX_W-1:0] idx,
                            logic [pcli_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        pcli_pkg::REG_INV_X:   inv_len[0] = data;
        pcli_pkg::REG_INV_Y:   inv_len[1] = data;
        pcli_pkg::REG_INV_Z:   inv_len[2] = data;
        pcli_pkg::REG_CELLS_X: cells[0]   = data[pcli_pkg::CNT_W-1:0];
        pcli_pkg::REG_CELLS_Y: cells[1]   = data[pcli_pkg::CNT_W-1:0];
        pcli_pkg::REG_CELLS_Z: cells[2]   = data[pcli_pkg::CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero counts act as one cell, oversized counts saturate.
    function int unsigned eff_count(int axis);
      if (cells[axis] == 0) return 1;
      if (cells[axis] > MAX_CELLS) return MAX_CELLS;
      return 32'(cells[axis]);
    endfunction

    // Keep the low 48 bits of the signed product, then scale by the count.
    function logic [pcli_pkg::COORD_W-1:0] bin_axis(logic signed [pcli_pkg::POS_W-1:0] pos,
                                                    logic [pcli_pkg::INV_W-1:0] inv,
                                                    int unsigned cnt);
      logic [63:0] wide;
      logic [63:0] prod;
      logic [63:0] scaled;
      wide   = {{32{pos[pcli_pkg::POS_W-1]}}, pos};
      prod   = wide * {32'd0, inv};
      scaled = {16'd0, prod[pcli_pkg::FRAC_W-1:0]} * 64'(cnt);
      return scaled[pcli_pkg::FRAC_W+pcli_pkg::COORD_W-1:pcli_pkg::FRAC_W];
    endfunction

    function int unsigned step_cell(int unsigned n, int unsigned cnt, pcli_pkg::var_t sel);
      case (sel)
        pcli_pkg::VAR_NEXT: return (n + 1 < cnt) ? n + 1 : 0;
        pcli_pkg::VAR_PREV: return (n > 0) ? n - 1 : cnt - 1;
        default:            return n;
      endcase
    endfunction

    function cell_res_t make_cell(int unsigned x, int unsigned y, int unsigned z,
                                  int unsigned cx, int unsigned cy, logic fin);
      int unsigned lin;
      cell_res_t   c;
      lin     = x + y * cx + z * cx * cy;
      c.index = lin[pcli_pkg::IDX_W-1:0];
      c.x     = x[pcli_pkg::COORD_W-1:0];
      c.y     = y[pcli_pkg::COORD_W-1:0];
      c.z     = z[pcli_pkg::COORD_W-1:0];
      c.last  = fin;
      return c;
    endfunction

    // Append one expected cell at the tail of the queue.
    function void expect_cell(cell_res_t c);
      pending_cells.insert(pending_cells.size(), c);
    endfunction

    function void note_request(pcli_pkg::cmd_t cmd,
                               logic signed [pcli_pkg::POS_W-1:0] px, py, pz,
                               logic [pcli_pkg::COORD_W-1:0] hx, hy, hz);
      int unsigned cx, cy, cz, ux, uy, uz;
      cx = eff_count(0);
      cy = eff_count(1);
      cz = eff_count(2);
      if (cmd == pcli_pkg::CMD_BIN) begin
        expect_cell(make_cell(bin_axis(px, inv_len[0], cx),
                              bin_axis(py, inv_len[1], cy),
                              bin_axis(pz, inv_len[2], cz), cx, cy, 1'b1));
      end else begin
        ux = (hx >= cx) ? cx - 1 : hx;
        uy = (hy >= cy) ? cy - 1 : hy;
        uz = (hz >= cz) ? cz - 1 : hz;
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++)
            for (int c = 0; c < 3; c++)
              expect_cell(make_cell(step_cell(ux, cx, walk[a]),
                                    step_cell(uy, cy, walk[b]),
                                    step_cell(uz, cz, walk[c]), cx, cy,
                                    a == 2 && b == 2 && c == 2));
      end
    endfunction

    function void check_result(cell_res_t got);
      cell_res_t want;
      checked++;
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("%0t: unexpected cell idx=%0d (%0d,%0d,%0d) last=%0b", $time,
                   got.index, got.x, got.y, got.z, got.last);
        return;
      end
      want = pending_cells.pop_front();
      if (got.index !== want.index || got.x !== want.x || got.y !== want.y ||
          got.z !== want.z || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display({"%0t: cell mismatch, expected idx=%0d (%0d,%0d,%0d) last=%0b,",
                    " got idx=%0d (%0d,%0d,%0d) last=%0b"},
                   $time, want.index, want.x, want.y, want.z, want.last,
                   got.index, got.x, got.y, got.z, got.last);
      end
    endfunction

    function int pending();
      return pending_cells.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  logic                                 in_valid;
  logic                                 in_stall;
  logic                                 command;
  logic signed [pcli_pkg::POS_W-1:0]    pos_x, pos_y, pos_z;
  logic [pcli_pkg::COORD_W-1:0]         home_x, home_y, home_z;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [pcli_pkg::IDX_W-1:0]           cell_index;
  logic [pcli_pkg::COORD_W-1:0]         cell_x, cell_y, cell_z;
  logic                                 last;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [pcli_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [pcli_pkg::CFG_DATA_W-1:0]      cfg_data;

  cell_scoreboard sb = new();

  // Idle rates, in cycles per hundred, for the request sender and the result receiver.
  int unsigned send_gap_pct   = 21;
  int unsigned recv_stall_pct = 78;

  int unsigned bin_count   = 0;
  int unsigned neigh_count = 0;
  int unsigned cfg_writes  = 0;

  periodic_cell_list_indexer_top #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .home_x     (home_x),
    .home_y     (home_y),
    .home_z     (home_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_index (cell_index),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_z     (cell_z),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the result side at random; a rate of zero gives a clean stretch.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watch all three channels at the edge. Every driven input changes only
  // through nonblocking assignments, so the values seen here are the ones
  // the block samples at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        sb.note_request(pcli_pkg::cmd_t'(command), pos_x, pos_y, pos_z,
                        home_x, home_y, home_z);
        if (command == pcli_pkg::CMD_NEIGH) neigh_count++;
        else bin_count++;
      end
      if (out_valid && !out_stall)
        sb.check_result(cell_res_t'{cell_index, cell_x, cell_y, cell_z, last});
    end
  end

  // Present one request, after a random number of idle cycles, and hold it
  // until accepted. Valid stays high on return so that back-to-back
  // requests never drop it in between.
  task automatic send_request(input pcli_pkg::cmd_t cmd,
                              input logic signed [pcli_pkg::POS_W-1:0] px, py, pz,
                              input logic [pcli_pkg::COORD_W-1:0] hx, hy, hz);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    pos_x    <= px;
    pos_y    <= py;
    pos_z    <= pz;
    home_x   <= hx;
    home_y   <= hy;
    home_z   <= hz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop the request valid and wait until every expected cell has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pcli_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcli_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reprogram all six registers with the block idle, plus one write to a
  // spare index that must change nothing.
  task automatic load_config(input logic [pcli_pkg::CFG_DATA_W-1:0] ix, iy, iz, cx, cy, cz);
    drain();
    write_reg(pcli_pkg::REG_INV_X, ix);
    write_reg(pcli_pkg::REG_INV_Y, iy);
    write_reg(pcli_pkg::REG_INV_Z, iz);
    write_reg(pcli_pkg::REG_CELLS_X, cx);
    write_reg(pcli_pkg::REG_CELLS_Y, cy);
    write_reg(pcli_pkg::REG_CELLS_Z, cz);
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Mix fully random inverse lengths with small ones and with the inverse
  // of a plausible box length between one and sixty-four units.
  function automatic logic [pcli_pkg::CFG_DATA_W-1:0] pick_inv();
    logic [63:0] box;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(1, 32'hFFFF);
      default: begin
        box = 64'($urandom_range(32'h10001, 32'h400000));
        return 32'(64'h1_0000_0000_0000 / box);
      end
    endcase
  endfunction

  // Mostly legal counts; now and then a zero or an oversized count, and
  // sometimes junk in the unused upper bits.
  function automatic logic [pcli_pkg::CFG_DATA_W-1:0] pick_cells();
    logic [pcli_pkg::CFG_DATA_W-1:0] word;
    word = $urandom();
    if ($urandom_range(0, 1)) word[pcli_pkg::CFG_DATA_W-1:pcli_pkg::CNT_W] = '0;
    case ($urandom_range(0, 9))
      0:       word[pcli_pkg::CNT_W-1:0] = '0;
      1:       word[pcli_pkg::CNT_W-1:0] = pcli_pkg::CNT_W'($urandom_range(33, 63));
      default: word[pcli_pkg::CNT_W-1:0] = pcli_pkg::CNT_W'($urandom_range(1, MAX_CELLS));
    endcase
    return word;
  endfunction

  // A quarter neighbour requests; positions either anywhere or near the
  // origin; home cells mostly inside the current grid.
  task automatic send_random_request();
    pcli_pkg::cmd_t                    cmd;
    logic signed [pcli_pkg::POS_W-1:0] p [3];
    logic [pcli_pkg::COORD_W-1:0]      h [3];
    cmd = ($urandom_range(0, 99) < 25) ? pcli_pkg::CMD_NEIGH : pcli_pkg::CMD_BIN;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 1)) p[i] = $urandom();
      else p[i] = $urandom_range(0, 32'h1FFFFF) - 32'h100000;
      if ($urandom_range(0, 9) < 7)
        h[i] = pcli_pkg::COORD_W'($urandom_range(0, sb.eff_count(i) - 1));
      else h[i] = pcli_pkg::COORD_W'($urandom_range(0, 31));
    end
    send_request(cmd, p[0], p[1], p[2], h[0], h[1], h[2]);
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    command   <= pcli_pkg::CMD_BIN;
    pos_x     <= '0;
    pos_y     <= '0;
    pos_z     <= '0;
    home_x    <= '0;
    home_y    <= '0;
    home_z    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= pcli_pkg::REG_INV_X;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Boxes of 10, 5 and 20 units on a 4 x 5 x 6 grid: origin, extremes,
    // a position one LSB short of the box edge, one exactly on it and a
    // negative one that wraps.
    load_config(32'd429496730, 32'd858993459, 32'd214748365, 32'd4, 32'd5, 32'd6);
    send_request(pcli_pkg::CMD_BIN, 32'sd0, 32'sd0, 32'sd0, 5'd0, 5'd0, 5'd0);
    send_request(pcli_pkg::CMD_BIN, 32'sh7FFFFFFF, 32'sh80000000, -32'sd1,
                 5'd31, 5'd31, 5'd31);
    send_request(pcli_pkg::CMD_BIN, 32'sd655359, 32'sd327680, -32'sd1310720,
                 5'd0, 5'd0, 5'd0);
    send_request(pcli_pkg::CMD_NEIGH, $urandom(), $urandom(), $urandom(), 5'd0, 5'd0, 5'd0);
    send_request(pcli_pkg::CMD_NEIGH, 32'sd0, 32'sd0, 32'sd0, 5'd3, 5'd4, 5'd5);
    send_request(pcli_pkg::CMD_NEIGH, 32'sd0, 32'sd0, 32'sd0, 5'd31, 5'd31, 5'd31);

    // Zero inverse length, full-scale inverse length, zero and oversized counts.
    load_config(32'd0, 32'hFFFFFFFF, 32'd1, 32'd0, 32'd63, 32'd32);
    send_request(pcli_pkg::CMD_BIN, $urandom(), 32'sh7FFFFFFF, 32'sh80000000,
                 5'd0, 5'd0, 5'd0);
    send_request(pcli_pkg::CMD_BIN, -32'sd1, -32'sd1, -32'sd1, 5'd31, 5'd31, 5'd31);
    send_request(pcli_pkg::CMD_NEIGH, 32'sd0, 32'sd0, 32'sd0, 5'd0, 5'd31, 5'd31);
    send_request(pcli_pkg::CMD_NEIGH, 32'sd0, 32'sd0, 32'sd0, 5'd17, 5'd0, 5'd0);

    // One, two and three cells per axis: neighbours repeat.
    load_config($urandom(), $urandom(), $urandom(), 32'd1, 32'd2, 32'd3);
    send_request(pcli_pkg::CMD_NEIGH, 32'sd0, 32'sd0, 32'sd0, 5'd0, 5'd0, 5'd0);
    send_request(pcli_pkg::CMD_NEIGH, 32'sd0, 32'sd0, 32'sd0, 5'd0, 5'd1, 5'd2);
    send_request(pcli_pkg::CMD_NEIGH, 32'sd0, 32'sd0, 32'sd0, 5'd31, 5'd31, 5'd31);
    send_request(pcli_pkg::CMD_BIN, $urandom(), $urandom(), $urandom(), 5'd0, 5'd0, 5'd0);

    // Largest grid: the top corner reaches the highest linear index.
    load_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd32, 32'd32, 32'd32);
    send_request(pcli_pkg::CMD_NEIGH, 32'sd0, 32'sd0, 32'sd0, 5'd31, 5'd31, 5'd31);
    send_request(pcli_pkg::CMD_NEIGH, 32'sd0, 32'sd0, 32'sd0, 5'd0, 5'd0, 5'd0);
    send_request(pcli_pkg::CMD_BIN, -32'sd1, 32'sh80000000, 32'sh7FFFFFFF,
                 5'd0, 5'd0, 5'd0);
    send_request(pcli_pkg::CMD_BIN, $urandom(), $urandom(), $urandom(), 5'd0, 5'd0, 5'd0);

    // Random part: a fresh grid per segment, idling swapped a third of the
    // way through and switched off for the last third.
    for (int s = 0; s < SEGMENTS; s++) begin
      if (s == SEGMENTS / 3) begin
        send_gap_pct   = 78;
        recv_stall_pct = 21;
      end
      if (s == 2 * SEGMENTS / 3) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      load_config(pick_inv(), pick_inv(), pick_inv(), pick_cells(), pick_cells(), pick_cells());
      repeat (SEG_ITEMS) send_random_request();
    end

    drain();
    repeat (16) @(posedge clk);

    $display("Covered %0d bin and %0d neighbour requests over %0d register writes.",
             bin_count, neigh_count, cfg_writes);
    $display("Checked %0d cell results, %0d mismatches, %0d still outstanding.",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_periodic_cell_list_indexer_top passed");
    end else begin
      $display("tb_periodic_cell_list_indexer_top failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5000000;
    $display("tb_periodic_cell_list_indexer_top failed");
    $finish;
  end

endmodule

[files.f]
rtl/pcli_pkg.sv
rtl/pcli_axis.sv
rtl/periodic_cell_list_indexer_top.sv
tb/tb_periodic_cell_list_indexer_top.sv
